// ----- src/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table for
// the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QW        = 16;   // quaternion component width, Q1.14
  localparam int PW        = 32;   // product width, Q2.28
  localparam int SW        = 35;   // exact sum width before saturation
  localparam int ARG_W     = 31;   // saturated Q2.28 argument width
  localparam int SQ_BITS   = 29;   // isqrt result bits (cosine up to 2^28)
  localparam int REM_W     = 58;   // radicand / remainder width
  localparam int XW        = 34;   // CORDIC x/y datapath width
  localparam int ZW        = 24;   // CORDIC angle accumulator, Q.20
  localparam int ANG_W     = 17;   // rounded Q2.13 angle before clamp
  localparam int ATAN_LEN  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [ZW-1:0]    HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [ANG_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [SW-1:0]    Q28_ONE     = 35'sd268435456;
  localparam logic signed [SW-1:0]    ARG_MAX     = 35'sd1073741823;
  localparam logic signed [SW-1:0]    ARG_MIN     = -35'sd1073741824;

  function automatic logic signed [ZW-1:0] atan_q20(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ARG_W-1:0] sat_arg(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    if (v > ARG_MAX) begin
      t = ARG_MAX;
    end else if (v < ARG_MIN) begin
      t = ARG_MIN;
    end else begin
      t = v;
    end
    return t[ARG_W-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [ANG_W-1:0] v,
                                                         input logic signed [ANG_W-1:0] lim);
    logic signed [ANG_W-1:0] t;
    if (v > lim) begin
      t = lim;
    end else if (v < -lim) begin
      t = -lim;
    end else begin
      t = v;
    end
    return t;
  endfunction

endpackage

// ----- src/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q2.13 radians, unclamped.
// One quadrant pre-rotation stage, one stage per iteration, one rounding stage.
// ----------------------------------------------------------------------------
module qte_cordic #(
  parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [qte_pkg::ARG_W-1:0]    in_y,
  input  logic signed [qte_pkg::ARG_W-1:0]    in_x,
  output logic                                out_vld,
  output logic signed [qte_pkg::ANG_W-1:0]    out_angle
);
  import qte_pkg::*;

  logic                 vld_r  [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic signed [XW-1:0] x_r    [0:STEPS];
  logic signed [XW-1:0] y_r    [0:STEPS];
  logic signed [ZW-1:0] z_r    [0:STEPS];
  logic                 out_vld_r;
  logic signed [ANG_W-1:0] angle_r;

  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic signed [XW-1:0] xe, ye;

  assign xe = XW'(in_x);
  assign ye = XW'(in_y);

  // Turn left half-plane vectors by +-pi/2 so the iterations converge
  always_comb begin
    x0_nxt = xe;
    y0_nxt = ye;
    z0_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x0_nxt = ye;
        y0_nxt = -xe;
        z0_nxt = HALF_PI_Q20;
      end else begin
        x0_nxt = -ye;
        y0_nxt = xe;
        z0_nxt = -HALF_PI_Q20;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    x_r[0]    <= x0_nxt;
    y_r[0]    <= y0_nxt;
    z_r[0]    <= z0_nxt;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + atan_q20(i);
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - atan_q20(i);
      end
    end
  end

  logic signed [ZW-1:0] zr;
  assign zr = (z_r[STEPS] + ZW'(64)) >>> 7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[STEPS];
    end
    angle_r <= zero_r[STEPS] ? '0 : zr[ANG_W-1:0];
  end

  assign out_vld   = out_vld_r;
  assign out_angle = angle_r;

endmodule

// ----- src/quaternion_to_euler_angles_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Unit quaternion (Q1.14) to ZYX roll, pitch, yaw (Q2.13 radians).
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  ---------+------------------------------------+----------------------------
//  input    | in_quat_w/x/y/z                    | start && !busy
//  result   | out_roll/pitch/yaw_angle, clamped  | out_strobe, one cycle
//
// One quaternion is taken every cycle; busy stays low. The path runs through
// the three input/product/sum stages, the square and radicand stages,
// 29 one-bit isqrt stages, the pitch CORDIC (CORDIC_STEPS + 2 stages)
// and the output register.
// Reset clears only the valid bits. The result side cannot stall.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qte_pkg::QW-1:0]     in_quat_w,
  input  logic signed [qte_pkg::QW-1:0]     in_quat_x,
  input  logic signed [qte_pkg::QW-1:0]     in_quat_y,
  input  logic signed [qte_pkg::QW-1:0]     in_quat_z,
  output logic                              out_strobe,
  output logic signed [15:0]                out_roll_angle,
  output logic signed [14:0]                out_pitch_angle,
  output logic signed [15:0]                out_yaw_angle,
  output logic                              out_pitch_clamped
);
  import qte_pkg::*;

  localparam int LAT_C   = CORDIC_STEPS + 2;
  localparam int DLY_RY  = SQ_BITS + 2;
  localparam int DLY_CL  = DLY_RY + LAT_C;

  assign busy = 1'b0;

  // Stage 1: input register
  logic v1_r;
  logic signed [QW-1:0] w_r, x_r, y_r, z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    w_r <= in_quat_w;
    x_r <= in_quat_x;
    y_r <= in_quat_y;
    z_r <= in_quat_z;
  end

  // Stage 2: products
  logic v2_r;
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    wx_r <= w_r * x_r;
    yz_r <= y_r * z_r;
    xx_r <= x_r * x_r;
    yy_r <= y_r * y_r;
    wy_r <= w_r * y_r;
    zx_r <= z_r * x_r;
    wz_r <= w_r * z_r;
    xy_r <= x_r * y_r;
    zz_r <= z_r * z_r;
  end

  // Stage 3: sums, saturation, pitch clamp decision
  logic signed [SW-1:0] rn_s, rd_s, yn_s, yd_s, s_s;
  logic signed [ARG_W-1:0] s_sat, s_abs;
  assign rn_s = (SW'(wx_r) + SW'(yz_r)) <<< 1;
  assign rd_s = Q28_ONE - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
  assign yn_s = (SW'(wz_r) + SW'(xy_r)) <<< 1;
  assign yd_s = Q28_ONE - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
  assign s_s  = (SW'(wy_r) - SW'(zx_r)) <<< 1;
  assign s_sat = sat_arg(s_s);
  assign s_abs = (s_sat < 0) ? -s_sat : s_sat;

  logic v3_r, clamp3_r, neg3_r;
  logic signed [ARG_W-1:0] rn_r, rd_r, yn_r, yd_r, s3_r;
  logic [27:0] sabs3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    rn_r     <= sat_arg(rn_s);
    rd_r     <= sat_arg(rd_s);
    yn_r     <= sat_arg(yn_s);
    yd_r     <= sat_arg(yd_s);
    s3_r     <= s_sat;
    neg3_r   <= s_sat[ARG_W-1];
    clamp3_r <= (SW'(s_sat) >= Q28_ONE) || (SW'(s_sat) <= -Q28_ONE);
    sabs3_r  <= ((SW'(s_sat) >= Q28_ONE) || (SW'(s_sat) <= -Q28_ONE)) ? '0 : s_abs[27:0];
  end

  // Integer square root state, one result bit per stage, MSB first
  logic                    sq_vld_r [0:SQ_BITS];
  logic [REM_W-1:0]        sq_rem_r [0:SQ_BITS];
  logic [SQ_BITS-1:0]      sq_res_r [0:SQ_BITS];
  logic signed [ARG_W-1:0] sq_s_r   [0:SQ_BITS];

  // Stage 4: square of |s|; stage 5: radicand 2^56 - s^2 into the root chain
  logic v4_r;
  logic [55:0] sq4_r;
  logic signed [ARG_W-1:0] s4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      sq_vld_r[0] <= 1'b0;
    end else begin
      v4_r        <= v3_r;
      sq_vld_r[0] <= v4_r;
    end
    sq4_r       <= sabs3_r * sabs3_r;
    s4_r        <= s3_r;
    sq_rem_r[0] <= (REM_W'(1) << 56) - REM_W'(sq4_r);
    sq_res_r[0] <= '0;
    sq_s_r[0]   <= s4_r;
  end

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
    localparam int B = SQ_BITS - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = (REM_W'(sq_res_r[k]) << (B + 1)) + (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
      sq_s_r[k+1] <= sq_s_r[k];
      if (sq_rem_r[k] >= trial) begin
        sq_rem_r[k+1] <= sq_rem_r[k] - trial;
        sq_res_r[k+1] <= sq_res_r[k] | (SQ_BITS'(1) << B);
      end else begin
        sq_rem_r[k+1] <= sq_rem_r[k];
        sq_res_r[k+1] <= sq_res_r[k];
      end
    end
  end

  // CORDIC lanes
  logic roll_vld, yaw_vld, pitch_vld;
  logic signed [ANG_W-1:0] roll_ang, yaw_ang, pitch_ang;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .in_y(rn_r), .in_x(rd_r),
    .out_vld(roll_vld), .out_angle(roll_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .rst_n(rst_n), .in_vld(v3_r), .in_y(yn_r), .in_x(yd_r),
    .out_vld(yaw_vld), .out_angle(yaw_ang)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld_r[SQ_BITS]), .in_y(sq_s_r[SQ_BITS]),
    .in_x(ARG_W'(sq_res_r[SQ_BITS])),
    .out_vld(pitch_vld), .out_angle(pitch_ang)
  );

  // Align roll/yaw with pitch; carry the clamp decision alongside
  logic signed [ANG_W-1:0] roll_d_r [0:DLY_RY-1];
  logic signed [ANG_W-1:0] yaw_d_r  [0:DLY_RY-1];
  logic [1:0]              cl_d_r   [0:DLY_CL-1];

  always_ff @(posedge clk) begin
    roll_d_r[0] <= clamp_ang(roll_ang, PI_Q13);
    yaw_d_r[0]  <= clamp_ang(yaw_ang, PI_Q13);
    for (int i = 1; i < DLY_RY; i++) begin
      roll_d_r[i] <= roll_d_r[i-1];
      yaw_d_r[i]  <= yaw_d_r[i-1];
    end
    cl_d_r[0] <= {clamp3_r, neg3_r};
    for (int i = 1; i < DLY_CL; i++) begin
      cl_d_r[i] <= cl_d_r[i-1];
    end
  end

  // Entry k holds the CORDIC output after k + 1 registers; the last entry meets pitch
  logic signed [ANG_W-1:0] roll_al, yaw_al, pitch_sel;
  logic [1:0]              cl_al;
  assign roll_al = roll_d_r[DLY_RY-1];
  assign yaw_al  = yaw_d_r[DLY_RY-1];
  assign cl_al   = cl_d_r[DLY_CL-1];

  always_comb begin
    if (cl_al[1]) begin
      pitch_sel = cl_al[0] ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      pitch_sel = clamp_ang(pitch_ang, HALF_PI_Q13);
    end
  end

  // Output register: one strobe per transaction
  logic strobe_r, clamped_r;
  logic signed [15:0] roll_out_r, yaw_out_r;
  logic signed [14:0] pitch_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= pitch_vld & roll_vld | pitch_vld & yaw_vld | pitch_vld;
    end
    roll_out_r  <= roll_al[15:0];
    yaw_out_r   <= yaw_al[15:0];
    pitch_out_r <= pitch_sel[14:0];
    clamped_r   <= cl_al[1];
  end

  assign out_strobe        = strobe_r;
  assign out_roll_angle    = roll_out_r;
  assign out_pitch_angle   = pitch_out_r;
  assign out_yaw_angle     = yaw_out_r;
  assign out_pitch_clamped = clamped_r;

endmodule
